[src/sliding_hist_pkg.sv]
// shared widths and default sizes for the sliding-scale pulse histogram
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package sliding_hist_pkg;

  // fixed field widths of the pulse and result requests
  localparam int CODE_W      = 12;
  localparam int OFS_OUT_W   = 7;
  localparam int BIN_W       = 10;
  localparam int COUNT_OUT_W = 24;

  // default sizes handed to the top level parameters
  localparam int NUM_BINS_DEF   = 1024;
  localparam int COUNT_BITS_DEF = 24;
  localparam int OFFSET_TOP_DEF = 127;

endpackage

[src/sliding_scale_pulse_histogram.sv]
// sliding-scale pulse-height histogram, top level with control sequencer
// depends on sliding_hist_pkg, sliding_hist_offset_gen, sliding_hist_bin_store
//
// usage:
//   pulse requests (adc_code, source_stable) enter on in_valid / in_ready.
//   one result request per pulse leaves on out_valid / out_ready, carrying the
//   offset used, the addressed bin, the new count and the overflow flags.
//   cfg_wr_en / cfg_wr_data write accumulate_enable at any clock edge outside reset.
// sequence:
//   a pulse is taken in ST_IDLE (bin read issued); in ST_CALC, once the output
//   register is free, the registered bin data is used, the incremented count is
//   written back and the output register loaded. a new pulse is taken only after
//   ST_CALC is left; out_valid rises with the load of the output register.
// reset:
//   rst clears the offset, the error flag and sets accumulate_enable; then
//   the bin memory is swept to zero, one bin a cycle, through all NUM_BINS bins,
//   with in_ready low. configuration writes are still taken.
// stalls:
//   a result held by out_ready low stays in the output register; the next
//   pulse may be accepted meanwhile and waits with its bin read done.
`timescale 1ns / 1ps

module sliding_scale_pulse_histogram
  import sliding_hist_pkg::*;
#(
  parameter int NUM_BINS   = NUM_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int OFFSET_TOP = OFFSET_TOP_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CODE_W-1:0]      adc_code,
  input  logic                   source_stable,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OFS_OUT_W-1:0]   dac_offset,
  output logic [BIN_W-1:0]       bin_index,
  output logic                   counted,
  output logic [COUNT_OUT_W-1:0] count_value,
  output logic                   overflow,
  output logic                   rearm_detector,
  output logic                   error_sticky
);

  localparam int ADDR_W = $clog2(NUM_BINS);
  localparam int OFS_W  = (OFFSET_TOP > 1) ? $clog2(OFFSET_TOP + 1) : 1;
  localparam logic [COUNT_BITS:0] LIMIT = (COUNT_BITS + 1)'((64'd1 << COUNT_BITS) - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CALC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic accumulate_enable;
  logic error_flag;

  logic             in_fire;
  logic             calc_fire;
  logic             clear_busy;
  logic [OFS_W-1:0] offset;

  logic [CODE_W-1:0] offset_ext;
  logic [CODE_W-1:0] code_diff;
  logic [BIN_W-1:0]  bin_calc;
  logic              hit_calc;

  logic                 pend_hit;
  logic [BIN_W-1:0]     pend_bin;
  logic [OFS_OUT_W-1:0] pend_ofs;

  logic [COUNT_BITS-1:0] rd_data;
  logic [COUNT_BITS:0]   count_inc;
  logic                  inc_ok;
  logic                  wr_en;
  logic                  ovf_now;

  sliding_hist_offset_gen #(
    .OFFSET_TOP(OFFSET_TOP)
  ) u_offset (
    .clk   (clk),
    .rst   (rst),
    .step  (in_fire),
    .offset(offset)
  );

  // bin address from the pulse code and the offset in force
  assign offset_ext = CODE_W'(offset);
  assign code_diff  = adc_code - offset_ext;
  assign bin_calc   = code_diff[CODE_W-1:2];
  assign hit_calc   = source_stable && (adc_code >= offset_ext)
                      && (32'(bin_calc) < NUM_BINS);

  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign calc_fire = (state == ST_CALC) && (!out_valid || out_ready);

  // count limit sits just below all ones
  assign count_inc = {1'b0, rd_data} + 1'b1;
  assign inc_ok    = (count_inc < LIMIT) && accumulate_enable;
  assign wr_en     = calc_fire && pend_hit && inc_ok;
  assign ovf_now   = pend_hit && !inc_ok;

  sliding_hist_bin_store #(
    .NUM_BINS  (NUM_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_fire),
    .rd_addr   (ADDR_W'(bin_calc)),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (ADDR_W'(pend_bin)),
    .wr_data   (count_inc[COUNT_BITS-1:0]),
    .clear_busy(clear_busy)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (!clear_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (calc_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      accumulate_enable <= 1'b1;
      error_flag        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        accumulate_enable <= cfg_wr_data;
      end
      if (calc_fire && ovf_now) begin
        error_flag <= 1'b1;
      end
      if (calc_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pending pulse, held until its result is loaded
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_hit <= hit_calc;
      pend_bin <= bin_calc;
      pend_ofs <= OFS_OUT_W'(offset);
    end
  end

  always_ff @(posedge clk) begin
    if (calc_fire) begin
      dac_offset     <= pend_ofs;
      bin_index      <= pend_hit ? pend_bin : '0;
      counted        <= pend_hit && inc_ok;
      overflow       <= ovf_now;
      rearm_detector <= !ovf_now;
      error_sticky   <= error_flag || ovf_now;
      if (!pend_hit) begin
        count_value <= '0;
      end else if (inc_ok) begin
        count_value <= COUNT_OUT_W'(count_inc);
      end else begin
        count_value <= COUNT_OUT_W'(rd_data);
      end
    end
  end

  // one pulse in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("pulse accepted while another is in flight");

  // no pulse during the clearing sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !in_ready)
    else $error("pulse accepted during bin clearing");

  a_count_xor_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(counted && overflow))
    else $error("result both counted and overflowed");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |-> error_sticky)
    else $error("overflow without sticky error");

  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    error_flag |=> error_flag)
    else $error("sticky error cleared without reset");

endmodule

[src/sliding_hist_offset_gen.sv]
// sliding-scale offset generator: triangle count between 0 and OFFSET_TOP
// depends on sliding_hist_pkg
`timescale 1ns / 1ps

module sliding_hist_offset_gen
  import sliding_hist_pkg::*;
#(
  parameter int OFFSET_TOP = OFFSET_TOP_DEF,
  localparam int OFS_W = (OFFSET_TOP > 1) ? $clog2(OFFSET_TOP + 1) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  output logic [OFS_W-1:0] offset
);

  localparam logic [OFS_W-1:0] TOP = OFS_W'(OFFSET_TOP);

  logic [OFS_W-1:0] offset_value;
  logic [OFS_W-1:0] offset_value_next;
  logic             offset_falling;
  logic             offset_falling_next;

  always_comb begin
    offset_value_next   = offset_value;
    offset_falling_next = offset_falling;
    if (!offset_falling) begin
      offset_value_next = offset_value + 1'b1;
      if (offset_value_next == TOP) begin
        offset_falling_next = 1'b1;
      end
    end else begin
      offset_value_next = offset_value - 1'b1;
      if (offset_value_next == '0) begin
        offset_falling_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_value   <= '0;
      offset_falling <= 1'b0;
    end else if (step) begin
      offset_value   <= offset_value_next;
      offset_falling <= offset_falling_next;
    end
  end

  assign offset = offset_value;

endmodule

[src/sliding_hist_bin_store.sv]
// spectrum bin memory, one read and one write port, registered read data
// sweeps every bin to zero after reset; depends on sliding_hist_pkg
`timescale 1ns / 1ps

module sliding_hist_bin_store
  import sliding_hist_pkg::*;
#(
  parameter int NUM_BINS   = NUM_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int ADDR_W = $clog2(NUM_BINS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [ADDR_W-1:0]     rd_addr,
  output logic [COUNT_BITS-1:0] rd_data,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data,
  output logic                  clear_busy
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BINS - 1);

  logic [COUNT_BITS-1:0] mem [NUM_BINS];
  logic [ADDR_W-1:0]     clr_addr;
  logic                  clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign clear_busy = clearing;

endmodule
